FILE: rtl/ipc_pkg.sv
// Shared types, codes and lookup functions of the infix-to-postfix converter.
// No dependencies; every design module of the converter imports this package.
`default_nettype none

package ipc_pkg;

    // Operator codes held in the stack cells
    typedef logic [2:0] t_op_code;

    localparam t_op_code OP_LPAREN = 3'd0;
    localparam t_op_code OP_PLUS   = 3'd1;
    localparam t_op_code OP_MINUS  = 3'd2;
    localparam t_op_code OP_MUL    = 3'd3;
    localparam t_op_code OP_DIV    = 3'd4;
    localparam t_op_code OP_POW    = 3'd5;

    // Error codes carried on the result beat
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_INVALID   = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_OPEN      = 3'd3,
        ERR_FULL      = 3'd4
    } t_err;

    // Command broadcast to every stack cell
    typedef struct packed {
        logic init;
        logic push;
        logic pop;
    } t_stk_cmd;

    // ASCII character of an operator code
    function automatic logic [7:0] op_char(input t_op_code code);
        logic [7:0] c;
        case (code)
            OP_LPAREN: c = 8'h28;
            OP_PLUS:   c = 8'h2B;
            OP_MINUS:  c = 8'h2D;
            OP_MUL:    c = 8'h2A;
            OP_DIV:    c = 8'h2F;
            OP_POW:    c = 8'h5E;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    // Precedence of an operator code
    function automatic logic [1:0] op_prec(input t_op_code code);
        logic [1:0] p;
        case (code)
            OP_PLUS, OP_MINUS: p = 2'd1;
            OP_MUL, OP_DIV:    p = 2'd2;
            OP_POW:            p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

    // Operator code of a character; bit 3 flags a valid operator
    function automatic logic [3:0] code_of(input logic [7:0] sym);
        logic [3:0] r;
        case (sym)
            8'h2B:   r = {1'b1, OP_PLUS};
            8'h2D:   r = {1'b1, OP_MINUS};
            8'h2A:   r = {1'b1, OP_MUL};
            8'h2F:   r = {1'b1, OP_DIV};
            8'h5E:   r = {1'b1, OP_POW};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

endpackage

`default_nettype wire

FILE: rtl/ipc_cell.sv
// One cell of the operator stack: holds one operator code.
// Depends on ipc_pkg for the code type and the stack command struct.
`default_nettype none

module ipc_cell
    import ipc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_stk_cmd i_cmd,
    input  wire t_op_code i_from_above,
    input  wire t_op_code i_from_below,
    output t_op_code      o_code
);

    t_op_code r_code;

    // Load the sentinel on init, shift down on push, shift up on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= OP_LPAREN;
        end else if (i_cmd.init) begin
            r_code <= OP_LPAREN;
        end else if (i_cmd.push) begin
            r_code <= i_from_above;
        end else if (i_cmd.pop) begin
            r_code <= i_from_below;
        end
    end

    assign o_code = r_code;

endmodule

`default_nettype wire

FILE: rtl/ipc_stack.sv
// Operator stack built as a row of ipc_cell, top of stack in cell 0.
// Depends on ipc_pkg and ipc_cell.
`default_nettype none

module ipc_stack
    import ipc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_stk_cmd i_cmd,
    input  wire t_op_code i_code,
    output t_op_code      o_top
);

    t_op_code w_code [STACK_DEPTH];

    // Chain the cells: each takes from its neighbors above and below
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_op_code w_above;
        t_op_code w_below;
        if (g == 0) begin : g_top
            assign w_above = i_code;
        end else begin : g_mid
            assign w_above = w_code[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_below = OP_LPAREN;
        end else begin : g_inner
            assign w_below = w_code[g+1];
        end
        ipc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_code       (w_code[g])
        );
    end

    assign o_top = w_code[0];

endmodule

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_core.sv
// An operand's character is registered onto the result output; '(' only pushes
// the stack. An operator, ')' or end beat holds off the next input beat while
// the stack pops one cell per cycle whenever the output is not stalled.
// Output stalls hold the sequencer. Synchronous active-low reset leaves the
// stack holding only the '(' sentinel, discard mode off and no result pending.
// Depends on ipc_pkg and ipc_stack.
`default_nettype none

module infix_to_postfix_converter_core
    import ipc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] symbol
    input  wire logic        i_s_axis_tlast,   // is_end
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] out_symbol, [10:8] error_code
    output logic             o_m_axis_tlast    // last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OPPOP,
        S_CLOSE
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_disc, n_disc;
    t_op_code       r_code, n_code;
    logic           r_end, n_end;
    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_osym, n_osym;
    logic           r_olast, n_olast;
    t_err           r_oerr, n_oerr;

    t_stk_cmd       w_cmd;
    t_op_code       w_push_code;
    t_op_code       w_top;
    logic           w_can_emit;
    logic           w_accept;
    logic           w_full;
    logic           w_empty;
    logic [3:0]     w_code_of;

    ipc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_code  (w_push_code),
        .o_top   (w_top)
    );

    assign w_can_emit      = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_can_emit;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count >= CW'(STACK_DEPTH));
    assign w_empty         = (r_count == '0);
    assign w_code_of       = code_of(i_s_axis_tdata);

    // Sequence one input beat: emit, push, or pop the stack one cell per cycle while unstalled
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_disc      = r_disc;
        n_code      = r_code;
        n_end       = r_end;
        n_ovalid    = r_ovalid && !i_m_axis_tready;
        n_osym      = r_osym;
        n_olast     = r_olast;
        n_oerr      = r_oerr;
        w_cmd       = '0;
        w_push_code = r_code;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_disc) begin
                        // Drop beats until the end beat, then reinitialize
                        if (i_s_axis_tlast) begin
                            w_cmd.init = 1'b1;
                            n_count    = CW'(1);
                            n_disc     = 1'b0;
                        end
                    end else if (i_s_axis_tlast) begin
                        n_end   = 1'b1;
                        n_state = S_CLOSE;
                    end else if (i_s_axis_tdata == CH_LPAREN) begin
                        if (w_full) begin
                            n_ovalid = 1'b1;
                            n_osym   = 8'd0;
                            n_olast  = 1'b1;
                            n_oerr   = ERR_FULL;
                            n_disc   = 1'b1;
                        end else begin
                            w_push_code = OP_LPAREN;
                            w_cmd.push  = 1'b1;
                            n_count     = r_count + CW'(1);
                        end
                    end else if ((i_s_axis_tdata inside {[8'h30:8'h39]}) ||
                                 (i_s_axis_tdata inside {[8'h41:8'h5A]}) ||
                                 (i_s_axis_tdata inside {[8'h61:8'h7A]})) begin
                        n_ovalid = 1'b1;
                        n_osym   = i_s_axis_tdata;
                        n_olast  = 1'b0;
                        n_oerr   = ERR_NONE;
                    end else if (w_code_of[3]) begin
                        n_code  = w_code_of[2:0];
                        n_state = S_OPPOP;
                    end else if (i_s_axis_tdata == CH_RPAREN) begin
                        n_end   = 1'b0;
                        n_state = S_CLOSE;
                    end else begin
                        n_ovalid = 1'b1;
                        n_osym   = 8'd0;
                        n_olast  = 1'b1;
                        n_oerr   = ERR_INVALID;
                        n_disc   = 1'b1;
                    end
                end
            end

            S_OPPOP: begin
                if (w_can_emit) begin
                    if (w_empty) begin
                        n_ovalid = 1'b1;
                        n_osym   = 8'd0;
                        n_olast  = 1'b1;
                        n_oerr   = ERR_UNDERFLOW;
                        n_disc   = 1'b1;
                        n_state  = S_IDLE;
                    end else if (w_top == OP_LPAREN || w_top > OP_POW ||
                                 op_prec(w_top) < op_prec(r_code)) begin
                        // Stop popping and push the new operator, or flag an error if the stack is full
                        if (w_full) begin
                            n_ovalid = 1'b1;
                            n_osym   = 8'd0;
                            n_olast  = 1'b1;
                            n_oerr   = ERR_FULL;
                            n_disc   = 1'b1;
                        end else begin
                            w_cmd.push = 1'b1;
                            n_count    = r_count + CW'(1);
                        end
                        n_state = S_IDLE;
                    end else begin
                        w_cmd.pop = 1'b1;
                        n_count   = r_count - CW'(1);
                        n_ovalid  = 1'b1;
                        n_osym    = op_char(w_top);
                        n_olast   = 1'b0;
                        n_oerr    = ERR_NONE;
                    end
                end
            end

            S_CLOSE: begin
                if (w_can_emit) begin
                    if (w_empty) begin
                        n_ovalid = 1'b1;
                        n_osym   = 8'd0;
                        n_olast  = 1'b1;
                        n_oerr   = ERR_UNDERFLOW;
                        n_state  = S_IDLE;
                        if (r_end) begin
                            w_cmd.init = 1'b1;
                            n_count    = CW'(1);
                        end else begin
                            n_disc = 1'b1;
                        end
                    end else if (w_top == OP_LPAREN) begin
                        n_state = S_IDLE;
                        if (r_end) begin
                            // Terminator, or open-paren error if entries remain
                            n_ovalid   = 1'b1;
                            n_osym     = 8'd0;
                            n_olast    = 1'b1;
                            n_oerr     = (r_count != CW'(1)) ? ERR_OPEN : ERR_NONE;
                            w_cmd.init = 1'b1;
                            n_count    = CW'(1);
                        end else begin
                            w_cmd.pop = 1'b1;
                            n_count   = r_count - CW'(1);
                        end
                    end else begin
                        w_cmd.pop = 1'b1;
                        n_count   = r_count - CW'(1);
                        n_ovalid  = 1'b1;
                        n_osym    = op_char(w_top);
                        n_olast   = 1'b0;
                        n_oerr    = ERR_NONE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= CW'(1);
            r_disc   <= 1'b0;
            r_ovalid <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_disc   <= n_disc;
            r_ovalid <= n_ovalid;
            r_end    <= n_end;
        end
        r_code  <= n_code;
        r_osym  <= n_osym;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_oerr, r_osym};
    assign o_m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

FILE: rtl/ipc_chk.sv
// Port-level checker for infix_to_postfix_converter_core, bound to the top level.
// Depends on nothing beyond the top level's ports.
`default_nettype none

module ipc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] i_m_tdata,
    input wire logic        i_m_tlast
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) &&
        $stable(i_m_tlast))
        else $error("result beat changed while stalled");

    // Character beats carry no error
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tlast |-> i_m_tdata[10:8] == 3'd0)
        else $error("error code on a character beat");

    // Any error ends the expression
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[10:8] != 3'd0 |-> i_m_tlast)
        else $error("error beat not marked last");

    // Terminator and error beats carry a zero symbol
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tdata[7:0] == 8'd0 &&
        i_m_tdata[15:11] == 5'd0)
        else $error("nonzero symbol on last beat");

    // Reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result pending after reset");

endmodule

bind infix_to_postfix_converter_core ipc_chk u_ipc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);

`default_nettype wire
